// ===== src/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// Shared widths, reset values and register map for the button debounce block.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int BUTTONS    = 5;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int EVENT_W    = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);
  localparam logic [7:0]       ALL_RELEASED   = 8'hFF;

  typedef logic [BUTTONS-1:0] btn_vec_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [EVENT_W-1:0] event_t;

  typedef enum logic [PADDR_W-3:0] {
    REG_DEBOUNCE = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic     step;
    btn_vec_t raw;
    time_t    now;
  } bde_poll_t;

  typedef struct packed {
    event_t   press_event;
    btn_vec_t pressed;
  } bde_result_t;

endpackage

// ===== src/button_debounce_press_events_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_events_core
// Debounced button poller reporting the lowest newly pressed button.
// ----------------------------------------------------------------------------
// Takes one poll per clock cycle while the result side is not stalled. A
// poll lands in the input register, is evaluated against the per-button
// debounce state in one pass and leaves in the result register.
// The state update and the result register load happen at the same edge,
// which lets the next poll follow directly. Stalls on the result side hold
// both registers; the input side keeps taking an item whenever the input
// register moves on in that cycle.
module button_debounce_press_events_core import bde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BUTTONS-1:0] in_raw_buttons,
  input  logic [TIME_W-1:0]  in_now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [EVENT_W-1:0] out_press_event,
  output logic [BUTTONS-1:0] out_pressed_buttons,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic             in_valid_r,  in_valid_nxt;
  btn_vec_t         raw_r;
  time_t            now_r;
  logic             out_valid_r, out_valid_nxt;
  bde_result_t      result_r;
  bde_result_t      result;
  bde_poll_t        poll;
  logic             advance;
  logic [DEB_W-1:0] debounce_ms;

  bde_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .debounce_ms (debounce_ms)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;

  assign poll.step = advance;
  assign poll.raw  = raw_r;
  assign poll.now  = now_r;

  bde_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .debounce_ms (debounce_ms),
    .poll        (poll),
    .result      (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_r <= in_raw_buttons;
      now_r <= in_now_ms;
    end
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_press_event     = result_r.press_event;
  assign out_pressed_buttons = result_r.pressed;

endmodule

// ===== src/bde_cfg.sv =====
// ----------------------------------------------------------------------------
// bde_cfg
// APB-style register file holding the debounce time.
// ----------------------------------------------------------------------------
module bde_cfg import bde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [DEB_W-1:0]   debounce_ms
);

  logic [DEB_W-1:0] debounce_r;
  logic [DEB_W-1:0] debounce_nxt;
  reg_idx_t         reg_idx;
  logic             in_range;

  assign reg_idx  = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign in_range = (reg_idx == REG_DEBOUNCE);
  assign pready   = 1'b1;

  always_comb begin
    debounce_nxt = debounce_r;
    if (psel && penable && pwrite && in_range) begin
      debounce_nxt = pwdata[DEB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else begin
      debounce_r <= debounce_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (in_range) begin
      prdata = PDATA_W'(debounce_r);
    end
  end

  assign debounce_ms = debounce_r;

endmodule

// ===== src/bde_track.sv =====
// ----------------------------------------------------------------------------
// bde_track
// Per-button change tracking, debounce compare and press edge detection.
// ----------------------------------------------------------------------------
module bde_track import bde_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DEB_W-1:0] debounce_ms,
  input  bde_poll_t        poll,
  output bde_result_t      result
);

  btn_vec_t last_raw_r,     last_raw_nxt;
  btn_vec_t stable_r,       stable_nxt;
  btn_vec_t prev_pressed_r;
  time_t    change_time_r   [BUTTONS];
  time_t    change_time_nxt [BUTTONS];
  btn_vec_t changed;
  btn_vec_t settled;
  btn_vec_t pressed;
  btn_vec_t fresh;
  event_t   press_event;
  time_t    elapsed         [BUTTONS];

  always_comb begin
    for (int i = 0; i < BUTTONS; i++) begin
      changed[i]         = poll.raw[i] != last_raw_r[i];
      elapsed[i]         = poll.now - change_time_r[i];
      settled[i]         = !changed[i] && (elapsed[i] > TIME_W'(debounce_ms));
      change_time_nxt[i] = changed[i] ? poll.now : change_time_r[i];
      stable_nxt[i]      = settled[i] ? poll.raw[i] : stable_r[i];
    end
    last_raw_nxt = poll.raw;
    pressed      = ~stable_nxt;
    fresh        = pressed & ~prev_pressed_r;
    press_event  = '0;
    for (int i = BUTTONS - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        press_event = EVENT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r     <= ALL_RELEASED[BUTTONS-1:0];
      stable_r       <= ALL_RELEASED[BUTTONS-1:0];
      prev_pressed_r <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        change_time_r[i] <= '0;
      end
    end else if (poll.step) begin
      last_raw_r     <= last_raw_nxt;
      stable_r       <= stable_nxt;
      prev_pressed_r <= pressed;
      for (int i = 0; i < BUTTONS; i++) begin
        change_time_r[i] <= change_time_nxt[i];
      end
    end
  end

  assign result.press_event = press_event;
  assign result.pressed     = pressed;

endmodule

// ===== src/bde_checker.sv =====
// ----------------------------------------------------------------------------
// bde_checker
// Port-level checks on the button debounce block, bound to the top level.
// ----------------------------------------------------------------------------
module bde_checker import bde_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [EVENT_W-1:0] out_press_event,
  input logic [BUTTONS-1:0] out_pressed_buttons,
  input logic               pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_press_event)
      && $stable(out_pressed_buttons))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_press_event <= EVENT_W'(BUTTONS))
    else $error("press event out of range");

  a_event_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_event != '0
      |-> out_pressed_buttons[out_press_event - EVENT_W'(1)])
    else $error("reported press not in pressed vector");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind button_debounce_press_events_core bde_checker u_bde_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_press_event     (out_press_event),
  .out_pressed_buttons (out_pressed_buttons),
  .pready              (pready)
);
